@@ rtl/dtms_pkg.sv @@
// package for the debounced trigger mode selector
// widths, register indexes and reset values shared by the interfaces and the top level
package dtms_pkg;

  localparam int MsgCount = 4;
  localparam int MsgW = (MsgCount > 1) ? $clog2(MsgCount) : 1;

  localparam int DebW = 16;
  localparam int CntW = 20;
  localparam int HoldW = 17;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 20;
  localparam int CharW = 8;
  localparam int MsgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegDebounce = 2'd0;
  localparam cfg_idx_t RegIdle = 2'd1;
  localparam cfg_idx_t RegPulse = 2'd2;

  localparam logic [DebW-1:0] DebReset = 16'd50;
  localparam logic [CntW-1:0] IdleReset = 20'd30000;
  localparam logic [CntW-1:0] PulseReset = 20'd10000;

  localparam logic [CharW-1:0] AsciiOne = 8'h31;
  localparam logic [CharW-1:0] AsciiFour = 8'h34;

  localparam logic [CharW-1:0] MsgCycleTrig = 8'd3;
  localparam logic [CharW-1:0] MsgFront = 8'd1;
  localparam logic [CharW-1:0] MsgBack = 8'd2;
  localparam logic [CharW-1:0] MsgIdle = 8'd0;

  typedef logic [MsgW-1:0] msg_t;

  function automatic logic msg_ok(input logic [CharW-1:0] idx);
    msg_ok = (idx < CharW'(MsgCount));
  endfunction

endpackage

@@ rtl/dtms_if.sv @@
// valid/ready channel interfaces for tick items and results
// depends on dtms_pkg for field widths
interface dtms_in_if;
  import dtms_pkg::*;
  logic             valid;
  logic             ready;
  logic             cycle_button;
  logic             trigger_switch;
  logic             front_motion;
  logic             back_motion;
  logic             char_valid;
  logic [CharW-1:0] char_code;

  modport source (output valid, cycle_button, trigger_switch, front_motion, back_motion,
                  char_valid, char_code, input ready);
  modport sink (input valid, cycle_button, trigger_switch, front_motion, back_motion,
                char_valid, char_code, output ready);
endinterface

interface dtms_out_if;
  import dtms_pkg::*;
  logic               valid;
  logic               ready;
  logic [MsgIdxW-1:0] message_index;
  logic               play_request;
  logic               relay_level;

  modport source (output valid, message_index, play_request, relay_level, input ready);
  modport sink (input valid, message_index, play_request, relay_level, output ready);
endinterface

@@ rtl/debounced_trigger_mode_selector.sv @@
// top level of the debounced trigger mode selector
// depends on dtms_pkg and the channel interfaces in dtms_if.sv
//
//  channel   dir  transaction
//  in_ch     in   one tick: button, switch, sensor levels and serial character
//  out_ch    out  one result per tick: message index, play request, relay level
//  cfg_*     in   register write, no handshake
//
// the state update happens at input acceptance and the result lands in the output
// register on the same edge
// a new transaction is taken every cycle while the output register is empty or drained
// synchronous active-low reset restores register defaults and the released-button state
// a stalled output blocks input only while its result is still waiting
module debounced_trigger_mode_selector (
  input  logic                      clk,
  input  logic                      rst_n,
  dtms_in_if.sink                   in_ch,
  dtms_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  dtms_pkg::cfg_idx_t        cfg_index,
  input  logic [dtms_pkg::CfgDataW-1:0] cfg_data
);
  import dtms_pkg::*;

  logic [DebW-1:0]  deb_ticks_r;
  logic [CntW-1:0]  idle_ticks_r;
  logic [CntW-1:0]  pulse_ticks_r;

  logic             cyc_last_r, cyc_stable_r;
  logic [HoldW-1:0] cyc_hold_r;
  logic             trg_last_r, trg_stable_r;
  logic [HoldW-1:0] trg_hold_r;
  logic             front_last_r, back_last_r;
  msg_t             sel_r;
  logic [CntW-1:0]  idle_r;
  logic             pulse_act_r;
  logic [CntW-1:0]  pulse_cnt_r;

  logic             cyc_stable_nxt, trg_stable_nxt;
  logic [HoldW-1:0] cyc_hold_nxt, trg_hold_nxt;
  msg_t             sel_nxt;
  logic [CntW-1:0]  idle_nxt;
  logic             pulse_act_nxt;
  logic [CntW-1:0]  pulse_cnt_nxt;
  logic             play_nxt;

  logic               out_valid_r;
  logic [MsgIdxW-1:0] out_msg_r;
  logic               out_play_r;
  logic               out_relay_r;

  logic             in_fire;
  logic             cyc_press, trg_press;
  logic [CharW-1:0] char_idx;
  logic [CharW-1:0] cyc_idx;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.message_index = out_msg_r;
  assign out_ch.play_request = out_play_r;
  assign out_ch.relay_level = out_relay_r;

  assign char_idx = CharW'(in_ch.char_code - AsciiOne);
  assign cyc_idx = (CharW'(sel_r) + 8'd1 == CharW'(MsgCount)) ? 8'd0
                                                              : CharW'(sel_r) + 8'd1;

  always_comb begin
    // debounce
    if (in_ch.cycle_button != cyc_last_r) cyc_hold_nxt = '0;
    else if (cyc_hold_r == '1) cyc_hold_nxt = cyc_hold_r;
    else cyc_hold_nxt = HoldW'(cyc_hold_r + 1'b1);
    cyc_stable_nxt = cyc_stable_r;
    cyc_press = 1'b0;
    if (cyc_hold_nxt > {1'b0, deb_ticks_r} && in_ch.cycle_button != cyc_stable_r) begin
      cyc_stable_nxt = in_ch.cycle_button;
      cyc_press = !in_ch.cycle_button;
    end

    if (in_ch.trigger_switch != trg_last_r) trg_hold_nxt = '0;
    else if (trg_hold_r == '1) trg_hold_nxt = trg_hold_r;
    else trg_hold_nxt = HoldW'(trg_hold_r + 1'b1);
    trg_stable_nxt = trg_stable_r;
    trg_press = 1'b0;
    if (trg_hold_nxt > {1'b0, deb_ticks_r} && in_ch.trigger_switch != trg_stable_r) begin
      trg_stable_nxt = in_ch.trigger_switch;
      trg_press = !in_ch.trigger_switch;
    end

    // counters
    sel_nxt = sel_r;
    play_nxt = 1'b0;
    idle_nxt = (idle_r == '1) ? idle_r : CntW'(idle_r + 1'b1);
    pulse_act_nxt = pulse_act_r;
    pulse_cnt_nxt = (pulse_act_r && pulse_cnt_r != '1) ? CntW'(pulse_cnt_r + 1'b1)
                                                        : pulse_cnt_r;

    // selections in priority order, last wins
    if (cyc_press && msg_ok(cyc_idx)) begin
      sel_nxt = MsgW'(cyc_idx);
      idle_nxt = '0;
      play_nxt = 1'b1;
    end
    if (trg_press) begin
      if (msg_ok(MsgCycleTrig)) begin
        sel_nxt = MsgW'(MsgCycleTrig);
        idle_nxt = '0;
        play_nxt = 1'b1;
      end
      pulse_act_nxt = 1'b1;
      pulse_cnt_nxt = '0;
    end
    if (in_ch.front_motion && !front_last_r && msg_ok(MsgFront)) begin
      sel_nxt = MsgW'(MsgFront);
      idle_nxt = '0;
      play_nxt = 1'b1;
    end
    if (in_ch.back_motion && !back_last_r && msg_ok(MsgBack)) begin
      sel_nxt = MsgW'(MsgBack);
      idle_nxt = '0;
      play_nxt = 1'b1;
    end
    if (pulse_act_nxt && pulse_cnt_nxt >= pulse_ticks_r) pulse_act_nxt = 1'b0;
    if (in_ch.char_valid && in_ch.char_code >= AsciiOne && in_ch.char_code <= AsciiFour &&
        msg_ok(char_idx)) begin
      sel_nxt = MsgW'(char_idx);
      idle_nxt = '0;
      play_nxt = 1'b1;
    end
    if (idle_nxt >= idle_ticks_r && msg_ok(MsgIdle)) begin
      sel_nxt = MsgW'(MsgIdle);
      idle_nxt = '0;
      play_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r <= DebReset;
      idle_ticks_r <= IdleReset;
      pulse_ticks_r <= PulseReset;
      cyc_last_r <= 1'b1;
      cyc_stable_r <= 1'b1;
      cyc_hold_r <= '0;
      trg_last_r <= 1'b1;
      trg_stable_r <= 1'b1;
      trg_hold_r <= '0;
      front_last_r <= 1'b0;
      back_last_r <= 1'b0;
      sel_r <= '0;
      idle_r <= '0;
      pulse_act_r <= 1'b0;
      pulse_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegDebounce: deb_ticks_r <= cfg_data[DebW-1:0];
          RegIdle:     idle_ticks_r <= cfg_data[CntW-1:0];
          RegPulse:    pulse_ticks_r <= cfg_data[CntW-1:0];
          default:     ;
        endcase
      end
      if (in_fire) begin
        cyc_last_r <= in_ch.cycle_button;
        cyc_stable_r <= cyc_stable_nxt;
        cyc_hold_r <= cyc_hold_nxt;
        trg_last_r <= in_ch.trigger_switch;
        trg_stable_r <= trg_stable_nxt;
        trg_hold_r <= trg_hold_nxt;
        front_last_r <= in_ch.front_motion;
        back_last_r <= in_ch.back_motion;
        sel_r <= sel_nxt;
        idle_r <= idle_nxt;
        pulse_act_r <= pulse_act_nxt;
        pulse_cnt_r <= pulse_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_msg_r <= MsgIdxW'(sel_nxt);
      out_play_r <= play_nxt;
      out_relay_r <= !pulse_act_nxt;
    end
  end

  a_relay_tracks_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_relay_r |-> pulse_act_r)
    else $error("relay low without an active pulse");

  a_play_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_play_r |-> idle_r == '0)
    else $error("play request without idle counter restart");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_msg_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_msg_r == MsgIdxW'(sel_r))
    else $error("message index out of step with selection");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for debounced_trigger_mode_selector
// needs dtms_pkg, the channel interfaces of dtms_if.sv and the top level
// a scoreboard class predicts every tick result; plain tasks drive ticks and register writes
module testbench;
  import dtms_pkg::*;

  localparam int StallLimit = 5000;

  typedef struct {
    logic [MsgIdxW-1:0] message_index;
    logic               play_request;
    logic               relay_level;
  } tick_result_t;

  class selector_scoreboard;
    logic [DebW-1:0]  debounce_lim;
    logic [CntW-1:0]  idle_lim;
    logic [CntW-1:0]  pulse_lim;
    logic             cyc_last, cyc_stable, trg_last, trg_stable;
    logic [HoldW-1:0] cyc_hold, trg_hold;
    logic             front_last, back_last;
    msg_t             sel;
    logic [CntW-1:0]  idle_cnt, pulse_cnt;
    logic             pulse_on, played;
    tick_result_t     expected_results[$];
    int               errors;
    int               checked;

    function new();
      debounce_lim = DebReset;
      idle_lim = IdleReset;
      pulse_lim = PulseReset;
      cyc_last = 1'b1; cyc_stable = 1'b1; cyc_hold = '0;
      trg_last = 1'b1; trg_stable = 1'b1; trg_hold = '0;
      front_last = 1'b0; back_last = 1'b0;
      sel = '0;
      idle_cnt = '0; pulse_cnt = '0;
      pulse_on = 1'b0; played = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
      case (idx)
        RegDebounce: debounce_lim = val[DebW-1:0];
        RegIdle:     idle_lim = val[CntW-1:0];
        RegPulse:    pulse_lim = val[CntW-1:0];
        default: ;
      endcase
    endfunction

    function void choose(input int unsigned idx);
      if (idx < MsgCount) begin
        sel = msg_t'(idx);
        idle_cnt = '0;
        played = 1'b1;
      end
    endfunction

    // true on an accepted press
    function bit debounce(input logic raw, inout logic last, inout logic stable,
                          inout logic [HoldW-1:0] hold);
      bit press;
      press = 1'b0;
      if (raw != last) hold = '0;
      else if (hold != '1) hold = hold + 1'b1;
      if (hold > debounce_lim && raw != stable) begin
        stable = raw;
        press = (raw == 1'b0);
      end
      last = raw;
      return press;
    endfunction

    function void note_tick(input logic cyc, trg, fr, bk, cv, input logic [CharW-1:0] code);
      tick_result_t r;
      played = 1'b0;
      if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
      if (pulse_on && pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
      if (debounce(cyc, cyc_last, cyc_stable, cyc_hold))
        choose((int'(sel) + 1) % MsgCount);
      if (debounce(trg, trg_last, trg_stable, trg_hold)) begin
        choose(int'(MsgCycleTrig));
        pulse_on = 1'b1;
        pulse_cnt = '0;
      end
      if (fr && !front_last) choose(int'(MsgFront));
      front_last = fr;
      if (bk && !back_last) choose(int'(MsgBack));
      back_last = bk;
      if (pulse_on && pulse_cnt >= pulse_lim) pulse_on = 1'b0;
      if (cv && code >= AsciiOne && code <= AsciiFour) choose(int'(code - AsciiOne));
      if (idle_cnt >= idle_lim) choose(int'(MsgIdle));
      r.message_index = MsgIdxW'(sel);
      r.play_request = played;
      r.relay_level = !pulse_on;
      expected_results.push_back(r);
    endfunction

    function void check_result(input logic [MsgIdxW-1:0] msg, input logic play, relay);
      tick_result_t e;
      if (expected_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: msg=%0d play=%0b relay=%0b", msg, play, relay);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (msg !== e.message_index || play !== e.play_request || relay !== e.relay_level) begin
          if (errors < 10)
            $display("mismatch at result %0d: expected msg=%0d play=%0b relay=%0b, %s",
                     checked, e.message_index, e.play_request, e.relay_level,
                     $sformatf("got msg=%0d play=%0b relay=%0b", msg, play, relay));
          errors++;
        end
      end
      checked++;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dtms_in_if in_ch();
  dtms_out_if out_ch();

  debounced_trigger_mode_selector DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  selector_scoreboard sb = new();

  int send_pct = 0;
  int recv_pct = 0;
  int stall_cycles = 0;

  logic cyc_lv = 1'b1, trg_lv = 1'b1, fr_lv = 1'b0, bk_lv = 1'b0;
  int cyc_run = 0, trg_run = 0;

  int unsigned deb_set[8] = '{50, 0, 65535, 2, 1, 0, 5, 12};
  int unsigned idle_set[8] = '{30000, 0, 1048575, 15, 1, 200, 40, 100};
  int unsigned pulse_set[8] = '{10000, 0, 1048575, 5, 1, 40, 0, 30};
  int phase_items[8] = '{250, 200, 150, 220, 180, 220, 220, 210};

  always #5 clk = ~clk;

  // result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.message_index, out_ch.play_request, out_ch.relay_level);
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic cyc, trg, fr, bk, cv, input logic [CharW-1:0] code);
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cycle_button <= cyc;
    in_ch.trigger_switch <= trg;
    in_ch.front_motion <= fr;
    in_ch.back_motion <= bk;
    in_ch.char_valid <= cv;
    in_ch.char_code <= code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(cyc, trg, fr, bk, cv, code);
  endtask

  // wait until every result is back and the block is quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DebW-1:0] d, input logic [CntW-1:0] il, pl);
    cfg_we <= 1'b1;
    cfg_index <= RegDebounce;
    cfg_data <= CfgDataW'(d);
    @(posedge clk);
    cfg_index <= RegIdle;
    cfg_data <= CfgDataW'(il);
    @(posedge clk);
    cfg_index <= RegPulse;
    cfg_data <= CfgDataW'(pl);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(RegDebounce, CfgDataW'(d));
    sb.set_reg(RegIdle, CfgDataW'(il));
    sb.set_reg(RegPulse, CfgDataW'(pl));
  endtask

  // bounces, long well-formed holds, or anything in between
  function automatic int run_len(input int span);
    case ($urandom_range(2))
      0: run_len = $urandom_range(3, 1);
      1: run_len = $urandom_range(span + 8, span + 2);
      default: run_len = $urandom_range(span + 6, 1);
    endcase
  endfunction

  task automatic run_random(input int count, input int unsigned deb);
    int span;
    logic [CharW-1:0] code;
    span = (deb > 60) ? 60 : int'(deb);
    repeat (count) begin
      if (cyc_run == 0) begin
        cyc_lv = ~cyc_lv;
        cyc_run = run_len(span);
      end
      cyc_run--;
      if (trg_run == 0) begin
        trg_lv = ~trg_lv;
        trg_run = run_len(span);
      end
      trg_run--;
      if ($urandom_range(7) == 0) fr_lv = ~fr_lv;
      if ($urandom_range(7) == 0) bk_lv = ~bk_lv;
      if ($urandom_range(1) == 0)
        code = CharW'($urandom_range(int'(AsciiFour) + 1, int'(AsciiOne) - 1));
      else
        code = CharW'($urandom_range(255));
      send_tick(cyc_lv, trg_lv, fr_lv, bk_lv, ($urandom_range(5) == 0), code);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cycle_button <= 1'b1;
    in_ch.trigger_switch <= 1'b1;
    in_ch.front_motion <= 1'b0;
    in_ch.back_motion <= 1'b0;
    in_ch.char_valid <= 1'b0;
    in_ch.char_code <= '0;
    cfg_we <= 1'b0;
    cfg_index <= RegDebounce;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short debounce so presses land within a few ticks
    write_regs(16'd1, 20'd8, 20'd2);
    send_tick(1, 1, 0, 0, 0, 8'h00);
    send_tick(0, 1, 0, 0, 0, 8'h00);
    send_tick(0, 1, 0, 0, 0, 8'h00);
    send_tick(0, 1, 0, 0, 0, 8'h00);
    send_tick(1, 1, 1, 0, 0, 8'h00);
    send_tick(1, 1, 1, 1, 0, 8'h00);
    send_tick(1, 1, 0, 0, 1, AsciiOne);
    send_tick(1, 0, 0, 0, 1, AsciiFour);
    send_tick(1, 0, 0, 0, 1, AsciiOne - 8'd1);
    send_tick(1, 0, 1, 0, 1, AsciiFour + 8'd1);
    send_tick(1, 1, 0, 0, 0, AsciiOne + 8'd1);
    send_tick(1, 1, 1, 1, 1, 8'hFF);
    send_tick(0, 0, 0, 0, 1, 8'h00);
    send_tick(0, 0, 0, 0, 0, AsciiOne + 8'd2);
    send_tick(0, 0, 0, 0, 0, 8'h00);
    repeat (9) send_tick(1, 1, 0, 0, 0, 8'h00);
    send_tick(1, 1, 0, 0, 1, AsciiOne + 8'd2);

    for (int p = 0; p < 8; p++) begin
      settle();
      write_regs(DebW'(deb_set[p]), CntW'(idle_set[p]), CntW'(pulse_set[p]));
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 77; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 77; end
        default: begin send_pct = 14; recv_pct = 14; end
      endcase
      run_random(phase_items[p], deb_set[p]);
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
